// ----- sv/arl_pkg.sv -----
// shared constants, word types and control structs for the antialiased line rasterizer
`default_nettype none
package arl_pkg;

  // coordinate format of the input words
  localparam int COORD_INT_BITS  = 12;
  localparam int COORD_FRAC_BITS = 4;
  localparam int COORD_W         = COORD_INT_BITS + COORD_FRAC_BITS;
  // screen coordinates carry one extra bit for the far pixel
  localparam int PIX_W           = COORD_INT_BITS + 1;
  localparam int BRIGHT_BITS     = 8;
  // default gradient precision
  localparam int SLOPE_FRAC_BITS = 16;

  // input function codes
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  typedef struct packed {
    logic               func;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
  } in_word_t;

  typedef struct packed {
    logic [PIX_W-1:0]       near_px;
    logic [PIX_W-1:0]       near_py;
    logic [BRIGHT_BITS-1:0] near_bright;
    logic [PIX_W-1:0]       far_px;
    logic [PIX_W-1:0]       far_py;
    logic [BRIGHT_BITS-1:0] far_bright;
    logic                   last_column;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_ENDS,
    ST_PAIRS
  } arl_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;       // latch ordered endpoints, seed the divider
    logic div_step;   // one quotient bit
    logic ends;       // slope and endpoint minor positions
    logic pairs;      // first and tail pairs, seed the column walk
    logic emit_tail;  // show the second endpoint pair
    logic emit_body;  // show one interior pair and advance
  } arl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic out_free;
    logic div_last;
    logic tail_last;
    logic body_last;
  } arl_sts_t;

endpackage
`default_nettype wire

// ----- sv/arl_ctrl.sv -----
// controller state machine: handshake, line state and sequencing of the datapath
`default_nettype none
module arl_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_func,
  output logic                    in_ready,
  input  wire arl_pkg::arl_sts_t  sts,
  output arl_pkg::arl_cmd_t       cmd
);

  arl_pkg::arl_state_t state_r, state_nxt;
  logic busy_r, busy_nxt;
  logic phase_r, phase_nxt;
  logic accept;

  assign in_ready = (state_r == arl_pkg::ST_IDLE) && sts.out_free;
  assign accept   = in_valid && in_ready;

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= arl_pkg::ST_IDLE;
      busy_r  <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
      phase_r <= phase_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    busy_nxt  = busy_r;
    phase_nxt = phase_r;
    cmd       = '0;
    case (state_r)
      arl_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_func == arl_pkg::FUNC_START) begin
            cmd.load  = 1'b1;
            busy_nxt  = 1'b0;
            state_nxt = arl_pkg::ST_DIV;
          end else if (busy_r) begin
            if (!phase_r) begin
              cmd.emit_tail = 1'b1;
              if (sts.tail_last) busy_nxt = 1'b0;
              else phase_nxt = 1'b1;
            end else begin
              cmd.emit_body = 1'b1;
              if (sts.body_last) busy_nxt = 1'b0;
            end
          end
        end
      end
      arl_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = arl_pkg::ST_ENDS;
      end
      arl_pkg::ST_ENDS: begin
        cmd.ends  = 1'b1;
        state_nxt = arl_pkg::ST_PAIRS;
      end
      arl_pkg::ST_PAIRS: begin
        cmd.pairs = 1'b1;
        busy_nxt  = 1'b1;
        phase_nxt = 1'b0;
        state_nxt = arl_pkg::ST_IDLE;
      end
      default: state_nxt = arl_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ----- sv/arl_dpath.sv -----
// datapath: endpoint ordering, slope divider, endpoint minors, pixel pair unit, output register
`default_nettype none
module arl_dpath #(
  parameter int SLOPE_FRAC_BITS = arl_pkg::SLOPE_FRAC_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire arl_pkg::arl_cmd_t  cmd,
  input  wire arl_pkg::in_word_t  in_word,
  output arl_pkg::arl_sts_t       sts,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output arl_pkg::out_word_t      out_word
);

  localparam int SF    = SLOPE_FRAC_BITS;
  localparam int CF    = arl_pkg::COORD_FRAC_BITS;
  localparam int CW    = arl_pkg::COORD_W;
  localparam int PW    = arl_pkg::PIX_W;
  localparam int BB    = arl_pkg::BRIGHT_BITS;
  localparam int ACC_W = CW + SF - CF + 2;
  localparam int SL_W  = SF + 2;
  localparam int DXE_W = CF + 2;
  localparam int CNT_W = $clog2(SF + 2);
  localparam int MUL_W = SF + CF + 2;
  localparam int BR_W  = SF + CF + BB + 3;
  localparam logic [CW:0]      HALF    = (CW+1)'(1 << (CF - 1));
  localparam logic [CF:0]      ONE_C   = (CF+1)'(1 << CF);
  localparam logic [SF:0]      ONE_S   = (SF+1)'(1) << SF;
  localparam logic [BR_W-1:0]  RND     = BR_W'(1) << (SF + CF - 1);

  // rounded column of a coordinate
  function automatic logic [PW-1:0] col_of(input logic [CW-1:0] x);
    logic [CW:0] s;
    s = {1'b0, x} + HALF;
    return s[CW:CF];
  endfunction

  // gap fraction of a coordinate, frac(x + 0.5)
  function automatic logic [CF:0] gfrac(input logic [CW-1:0] x);
    logic [CW:0] s;
    s = {1'b0, x} + HALF;
    return {1'b0, s[CF-1:0]};
  endfunction

  // minor position at the rounded column of an endpoint
  function automatic logic signed [ACC_W-1:0] end_minor(
    input logic [CW-1:0] x, input logic [CW-1:0] y, input logic signed [SL_W-1:0] sl);
    logic [PW+CF:0]              cx;
    logic [PW+CF:0]              d;
    logic signed [DXE_W-1:0]     dxe;
    logic signed [SL_W+DXE_W-1:0] p;
    logic signed [ACC_W-1:0]     base;
    cx   = {1'b0, col_of(x), CF'(0)};
    d    = cx - (PW+CF+1)'(x);
    dxe  = $signed(d[DXE_W-1:0]);
    p    = sl * dxe;
    base = $signed(ACC_W'({y, (SF-CF)'(0)}));
    return base + ACC_W'(p >>> CF);
  endfunction

  // brightness of one pixel from its weight and the column gap
  function automatic logic [BB-1:0] bright(input logic [SF:0] w, input logic [CF:0] gap);
    logic [MUL_W-1:0] p;
    logic [BR_W-1:0]  t;
    p = MUL_W'(w) * MUL_W'(gap);
    t = (BR_W'(p) << BB) - BR_W'(p) + RND;
    return t[SF+CF+BB-1:SF+CF];
  endfunction

  // pixel pair for one column
  function automatic arl_pkg::out_word_t mk_pair(
    input logic st, input logic [PW-1:0] major,
    input logic signed [ACC_W-1:0] ymin, input logic [CF:0] gap);
    arl_pkg::out_word_t      w;
    logic [SF:0]             fy;
    logic signed [ACC_W-1:0] mn;
    logic [PW-1:0]           m0;
    logic [PW-1:0]           m1;
    fy = {1'b0, ymin[SF-1:0]};
    mn = ymin >>> SF;
    m0 = mn[PW-1:0];
    m1 = m0 + PW'(1);
    w.near_bright = bright(ONE_S - fy, gap);
    w.far_bright  = bright(fy, gap);
    w.near_px     = st ? m0 : major;
    w.near_py     = st ? major : m0;
    w.far_px      = st ? m1 : major;
    w.far_py      = st ? major : m1;
    w.last_column = 1'b0;
    return w;
  endfunction

  // endpoint and divider registers
  logic [CW-1:0] x0_r, y0_r, x1_r, y1_r;
  logic [CW-1:0] dx_r;
  logic [CW-1:0] rem_r;
  logic          feed_r;
  logic          neg_r;
  logic          steep_r;
  logic [SF:0]   quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic signed [SL_W-1:0]  slope_r;
  logic signed [ACC_W-1:0] y0e_r, y1e_r;
  logic signed [ACC_W-1:0] accum_r;
  logic [PW-1:0] pos_r, stop_r;
  arl_pkg::out_word_t tail_r;
  arl_pkg::out_word_t out_r;
  logic          out_valid_r, out_valid_nxt;

  // endpoint ordering for a start word
  logic [CW-1:0] adx, ady, a0, b0, a1, b1, ux0, uy0, ux1, uy1;
  logic          steep, swap, dneg;
  always_comb begin
    adx   = (in_word.end_x > in_word.start_x) ? in_word.end_x - in_word.start_x
                                              : in_word.start_x - in_word.end_x;
    ady   = (in_word.end_y > in_word.start_y) ? in_word.end_y - in_word.start_y
                                              : in_word.start_y - in_word.end_y;
    steep = ady > adx;
    a0    = steep ? in_word.start_y : in_word.start_x;
    b0    = steep ? in_word.start_x : in_word.start_y;
    a1    = steep ? in_word.end_y : in_word.end_x;
    b1    = steep ? in_word.end_x : in_word.end_y;
    swap  = a0 > a1;
    ux0   = swap ? a1 : a0;
    uy0   = swap ? b1 : b0;
    ux1   = swap ? a0 : a1;
    uy1   = swap ? b0 : b1;
    dneg  = uy1 < uy0;
  end

  // restoring divide step
  logic [CW:0] trial;
  logic        ge;
  assign trial = {rem_r, feed_r};
  assign ge    = trial >= {1'b0, dx_r};

  // signed slope from the quotient
  logic signed [SL_W-1:0] slope_w;
  always_comb begin
    if (dx_r == '0) slope_w = $signed(SL_W'(ONE_S));
    else if (neg_r) slope_w = -$signed({1'b0, quo_r});
    else slope_w = $signed({1'b0, quo_r});
  end

  // pair units: a shared one for the first endpoint or an interior column, one for the tail
  arl_pkg::out_word_t pair_a, pair_t;
  always_comb begin
    if (cmd.pairs) pair_a = mk_pair(steep_r, col_of(x0_r), y0e_r, ONE_C - gfrac(x0_r));
    else pair_a = mk_pair(steep_r, pos_r, accum_r, ONE_C);
    pair_t = mk_pair(steep_r, col_of(x1_r), y1e_r, gfrac(x1_r));
  end

  logic [PW-1:0] pos_inc;
  assign pos_inc = pos_r + PW'(1);

  assign sts.out_free  = !out_valid_r || out_ready;
  assign sts.div_last  = (cnt_r == CNT_W'(SF));
  assign sts.tail_last = pos_r >= stop_r;
  assign sts.body_last = pos_inc >= stop_r;

  // emitted words with their last flag
  arl_pkg::out_word_t tail_w, body_w;
  always_comb begin
    tail_w             = tail_r;
    tail_w.last_column = sts.tail_last;
    body_w             = pair_a;
    body_w.last_column = sts.body_last;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x0_r    <= ux0;
      y0_r    <= uy0;
      x1_r    <= ux1;
      y1_r    <= uy1;
      steep_r <= steep;
      dx_r    <= ux1 - ux0;
      neg_r   <= dneg;
      rem_r   <= (dneg ? uy0 - uy1 : uy1 - uy0) >> 1;
      feed_r  <= dneg ? (uy0[0] ^ uy1[0]) : (uy1[0] ^ uy0[0]);
      quo_r   <= '0;
      cnt_r   <= '0;
    end
    if (cmd.div_step) begin
      rem_r  <= ge ? CW'(trial - {1'b0, dx_r}) : trial[CW-1:0];
      feed_r <= 1'b0;
      quo_r  <= {quo_r[SF-1:0], ge};
      cnt_r  <= cnt_r + CNT_W'(1);
    end
    if (cmd.ends) begin
      slope_r <= slope_w;
      y0e_r   <= end_minor(x0_r, y0_r, slope_w);
      y1e_r   <= end_minor(x1_r, y1_r, slope_w);
    end
    if (cmd.pairs) begin
      tail_r  <= pair_t;
      accum_r <= y0e_r + ACC_W'(slope_r);
      pos_r   <= col_of(x0_r) + PW'(1);
      stop_r  <= col_of(x1_r);
      out_r   <= pair_a;
    end
    if (cmd.emit_tail) begin
      out_r <= tail_w;
    end
    if (cmd.emit_body) begin
      out_r   <= body_w;
      pos_r   <= pos_inc;
      accum_r <= accum_r + ACC_W'(slope_r);
    end
  end

  // output word valid
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.pairs || cmd.emit_tail || cmd.emit_body) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= out_valid_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule
`default_nettype wire

// ----- sv/antialiased_line_raster.sv -----
// top level of the antialiased line rasterizer
//
//   channel  direction  handshake          word
//   in_      input      in_valid/in_ready  arl_pkg::in_word_t
//   out_     output     out_valid/out_ready arl_pkg::out_word_t
//
// a start word passes through endpoint ordering, the bit-serial slope divider,
// the endpoint minors and the pair unit before its first pair shows;
// a step word moves the next pair straight into the output register; words are
// taken only while the controller is idle and the output register is empty or
// being drained, so line setup and a stalled output hold off the input
// rst_n is synchronous and clears the controller and the output valid
`default_nettype none
module antialiased_line_raster #(
  parameter int SLOPE_FRAC_BITS = arl_pkg::SLOPE_FRAC_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire arl_pkg::in_word_t  in_word,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output arl_pkg::out_word_t      out_word
);

  arl_pkg::arl_cmd_t cmd;
  arl_pkg::arl_sts_t sts;

  // sequencing
  arl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_word.func),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // arithmetic and output register
  arl_dpath #(
    .SLOPE_FRAC_BITS (SLOPE_FRAC_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_word   (in_word),
    .sts       (sts),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule
`default_nettype wire

// ----- sv/arl_checker.sv -----
// port-level checker for the antialiased line rasterizer and its bind
`default_nettype none
module arl_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire arl_pkg::in_word_t  in_word,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire arl_pkg::out_word_t out_word
);

  // a stalled result word holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // no word is taken while a result is stalled
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken with full output register");

  // a start word keeps the input closed while the slope is divided
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_word.func == arl_pkg::FUNC_START) |=> !in_ready && !out_valid)
    else $error("input open during line setup");

  // reset empties the output
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind antialiased_line_raster arl_checker u_arl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);
`default_nettype wire

// ----- dv/tb_antialiased_line_raster.sv -----
// self-checking testbench for the antialiased line rasterizer
`timescale 1ns / 1ps
module tb_antialiased_line_raster;

  localparam int  HALF_PERIOD = 5;
  localparam int  ITEM_TARGET = 550;
  localparam int  QUIET_FROM  = 470;
  localparam int  WATCHDOG    = 3000;
  localparam int  SFB = arl_pkg::SLOPE_FRAC_BITS;
  localparam int  CFB = arl_pkg::COORD_FRAC_BITS;
  localparam int  PW  = arl_pkg::PIX_W;
  localparam int  BB  = arl_pkg::BRIGHT_BITS;
  localparam longint SLOPE_ONE = 64'd1 << SFB;
  localparam longint COORD_ONE = 64'd1 << CFB;
  localparam longint COORD_HALF = COORD_ONE >> 1;
  localparam longint PIX_MASK  = (64'd1 << PW) - 1;
  localparam longint BRIGHT_MAX = (64'd1 << BB) - 1;

  // line walk tracker and store of expected pixel pairs
  class line_scoreboard;
    arl_pkg::out_word_t expected_q[$];
    bit        line_busy;
    bit        steep;
    bit        walking;
    longint    col_pos;
    longint    col_stop;
    longint    minor_acc;
    longint    gradient;
    arl_pkg::out_word_t tail;
    int        errors;

    function arl_pkg::out_word_t make_pair(bit st, longint major, longint ymin, longint gap);
      arl_pkg::out_word_t p;
      longint fy, rw, minor, m0, m1, rnd;
      int sh;
      sh = SFB + CFB;
      rnd = 64'd1 << (sh - 1);
      fy = ymin & (SLOPE_ONE - 1);
      rw = SLOPE_ONE - fy;
      minor = ymin >>> SFB;
      m0 = minor & PIX_MASK;
      m1 = (minor + 1) & PIX_MASK;
      major = major & PIX_MASK;
      p.near_bright = BB'(((rw * gap * BRIGHT_MAX + rnd) >> sh) & BRIGHT_MAX);
      p.far_bright  = BB'(((fy * gap * BRIGHT_MAX + rnd) >> sh) & BRIGHT_MAX);
      if (st) begin
        p.near_px = PW'(m0); p.near_py = PW'(major); p.far_px = PW'(m1); p.far_py = PW'(major);
      end else begin
        p.near_px = PW'(major); p.near_py = PW'(m0); p.far_px = PW'(major); p.far_py = PW'(m1);
      end
      p.last_column = 1'b0;
      return p;
    endfunction

    // minor position of an endpoint at its rounded column
    function longint end_minor(longint x, longint y, longint col);
      longint dxe;
      dxe = (col << CFB) - x;
      return (y << (SFB - CFB)) + ((gradient * dxe) >>> CFB);
    endfunction

    function void note_word(arl_pkg::in_word_t w);
      longint x0, y0, x1, y1, t, dx, dy, mag, c0, c1, y0e;
      arl_pkg::out_word_t p;
      if (w.func == arl_pkg::FUNC_START) begin
        x0 = w.start_x; y0 = w.start_y; x1 = w.end_x; y1 = w.end_y;
        steep = ((y1 > y0) ? y1 - y0 : y0 - y1) > ((x1 > x0) ? x1 - x0 : x0 - x1);
        if (steep) begin
          t = x0; x0 = y0; y0 = t;
          t = x1; x1 = y1; y1 = t;
        end
        if (x0 > x1) begin
          t = x0; x0 = x1; x1 = t;
          t = y0; y0 = y1; y1 = t;
        end
        dx = x1 - x0;
        dy = y1 - y0;
        if (dx == 0) gradient = SLOPE_ONE;
        else begin
          mag = ((dy < 0 ? -dy : dy) << SFB) / dx;
          gradient = dy < 0 ? -mag : mag;
        end
        c0 = (x0 + COORD_HALF) >> CFB;
        c1 = (x1 + COORD_HALF) >> CFB;
        y0e = end_minor(x0, y0, c0);
        p = make_pair(steep, c0, y0e, COORD_ONE - ((x0 + COORD_HALF) & (COORD_ONE - 1)));
        tail = make_pair(steep, c1, end_minor(x1, y1, c1), (x1 + COORD_HALF) & (COORD_ONE - 1));
        minor_acc = y0e + gradient;
        col_pos = c0 + 1;
        col_stop = c1;
        walking = 1'b0;
        line_busy = 1'b1;
        expected_q.push_back(p);
      end else if (line_busy) begin
        if (!walking) begin
          p = tail;
          p.last_column = col_pos >= col_stop;
          walking = 1'b1;
        end else begin
          p = make_pair(steep, col_pos, minor_acc, COORD_ONE);
          col_pos++;
          minor_acc += gradient;
          p.last_column = col_pos >= col_stop;
        end
        if (p.last_column) line_busy = 1'b0;
        expected_q.push_back(p);
      end
    endfunction

    function void check_field(string name, longint exp_v, longint got_v);
      if (exp_v != got_v) begin
        $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_word(arl_pkg::out_word_t got);
      arl_pkg::out_word_t e;
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result word: expected none actual %h", $time, got);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      check_field("near_px", e.near_px, got.near_px);
      check_field("near_py", e.near_py, got.near_py);
      check_field("near_bright", e.near_bright, got.near_bright);
      check_field("far_px", e.far_px, got.far_px);
      check_field("far_py", e.far_py, got.far_py);
      check_field("far_bright", e.far_bright, got.far_bright);
      check_field("last_column", e.last_column, got.last_column);
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  arl_pkg::in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  arl_pkg::out_word_t out_word;

  line_scoreboard sb = new();
  int  items = 0;
  bit  quiet = 1'b0;
  int  stall_left = 0;
  int  idle_cycles = 0;

  antialiased_line_raster i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word)
  );

  always #HALF_PERIOD clk = ~clk;

  // result side: check accepted words, stall in random bursts
  always @(posedge clk) begin
    if (out_valid && out_ready) sb.check_word(out_word);
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 12);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // drive one word, hold until taken, then maybe leave a gap
  task automatic send_word(arl_pkg::in_word_t w);
    bit counts;
    counts = (w.func == arl_pkg::FUNC_START) || sb.line_busy;
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (!in_ready);
    sb.note_word(w);
    if (counts) items++;
    quiet = items >= QUIET_FROM;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic send_step();
    arl_pkg::in_word_t w;
    w = {arl_pkg::FUNC_STEP, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
    send_word(w);
  endtask

  // start a line, then step it to the end or until the step budget runs out
  task automatic draw_line(int x0, int y0, int x1, int y1, int max_steps);
    int k;
    send_word({arl_pkg::FUNC_START, 16'(x0), 16'(y0), 16'(x1), 16'(y1)});
    k = 0;
    while (sb.line_busy && k < max_steps) begin
      send_step();
      k++;
    end
  endtask

  function automatic int clamp_coord(int v);
    return v < 0 ? 0 : (v > 65535 ? 65535 : v);
  endfunction

  initial begin
    int x0, y0, len, dy, pick;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idle step, flat, steep, point, reversed, falling, extremes
    send_step();
    draw_line(16, 16, 80, 16, 100);
    draw_line(40, 20, 70, 300, 100);
    draw_line(100, 100, 100, 100, 100);
    draw_line(90, 37, 3, 5, 100);
    draw_line(10, 200, 140, 150, 100);
    draw_line(0, 0, 65535, 65535, 3);
    draw_line(65535, 0, 65520, 65535, 2);
    draw_line(65535, 65535, 65535, 65535, 100);
    draw_line(0, 0, 0, 0, 100);
    draw_line(23, 11, 40, 12, 100);
    // minor position falls below zero at the far endpoint
    draw_line(16, 40, 169, 0, 100);
    draw_line(40, 16, 0, 169, 100);
    send_step();

    // random lines, mostly short and complete
    while (items < ITEM_TARGET) begin
      pick = $urandom_range(0, 19);
      if (pick < 15) begin
        x0 = $urandom_range(0, 65535);
        y0 = $urandom_range(0, 65535);
        len = $urandom_range(0, 20 * 16);
        dy = $urandom_range(0, 2 * len) - len;
        if ($urandom_range(0, 1)) len = -len;
        if ($urandom_range(0, 1))
          draw_line(x0, y0, clamp_coord(x0 + len), clamp_coord(y0 + dy),
                    ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : 100);
        else
          draw_line(y0, x0, clamp_coord(y0 + dy), clamp_coord(x0 + len), 100);
      end else if (pick < 18) begin
        draw_line($urandom_range(0, 65535), $urandom_range(0, 65535),
                  $urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 5));
      end else begin
        send_step();
      end
    end
    in_valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
